// File: rtl/rsp_pkg.sv
package rsp_pkg;

	// Input coordinate and configuration widths
	localparam int COORD_W = 24;
	localparam int DL_W    = 23;
	localparam int COS_W   = 17;
	localparam int CD_W    = 24;

	// Reset values of the configuration registers
	localparam logic [DL_W-1:0]  DL_RESET  = 23'd32768;
	localparam logic [COS_W-1:0] COS_RESET = 17'd56756;

	// APB register map
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_DIST_LIMIT = 1'b0;
	localparam logic REG_COS_LIMIT  = 1'b1;

	// Back end arithmetic widths
	localparam int MUL_W     = 26;              // shared signed multiplier operand
	localparam int ACC_W     = 2 * MUL_W;       // product and accumulator
	localparam int SQ_W      = 50;              // sum of squared centre differences
	localparam int MAG_W     = 50;              // normal component magnitude
	localparam int RED_LIM   = 20;              // reduced normal magnitude below 2^20
	localparam int NRM_W     = RED_LIM + 1;     // reduced normal component, signed
	localparam int LL_W      = 2 * NRM_W;       // L1 * L2
	localparam int DOT_W     = 44;              // dot product of reduced normals
	localparam int RHS_W     = COS_W + LL_W;    // cos_limit * L1 * L2
	localparam int SQRT_IN_W = 52;
	localparam int SQRT_OUT_W = SQRT_IN_W / 2;

	typedef logic signed [COORD_W-1:0] coord_t;

	// First three plane atoms of one ring, x/y/z per atom
	typedef struct packed {
		logic [1:0]       seen;
		coord_t [8:0]     pt;
	} plane_t;

endpackage

// File: rtl/rsp_front.sv
module rsp_front #(
	parameter int MAX_RING_ATOMS = 16,
	parameter int CW = 5,
	parameter int SW = 29
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            ring_b,
	input  logic                            is_plane,
	input  logic signed [rsp_pkg::COORD_W-1:0] pos_x,
	input  logic signed [rsp_pkg::COORD_W-1:0] pos_y,
	input  logic signed [rsp_pkg::COORD_W-1:0] pos_z,
	input  logic                            last_atom,
	input  logic                            q_full,
	output logic                            q_push,
	output logic [6*SW-1:0]                 job_sums,
	output logic [2*CW-1:0]                 job_cnts,
	output rsp_pkg::plane_t                 job_plane_a,
	output rsp_pkg::plane_t                 job_plane_b
);

	logic signed [SW-1:0] sum_q [2][3];
	logic signed [SW-1:0] sum_n [2][3];
	logic [CW-1:0]        cnt_q [2];
	logic [CW-1:0]        cnt_n [2];
	rsp_pkg::plane_t      pl_q [2];
	rsp_pkg::plane_t      pl_n [2];
	rsp_pkg::coord_t      pos [3];
	logic [3:0]           pidx;
	logic                 acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && !q_full;
	assign q_push   = acc && ring_b && last_atom;

	// Next ring state with the incoming atom folded in
	always_comb begin
		pos[0] = pos_x;
		pos[1] = pos_y;
		pos[2] = pos_z;
		sum_n = sum_q;
		cnt_n = cnt_q;
		pl_n  = pl_q;
		pidx  = {2'b00, pl_q[ring_b].seen} * 4'd3;
		if (cnt_q[ring_b] < CW'(MAX_RING_ATOMS)) begin
			for (int k = 0; k < 3; k++) begin
				sum_n[ring_b][k] = sum_q[ring_b][k] + SW'(pos[k]);
			end
			cnt_n[ring_b] = cnt_q[ring_b] + 1'b1;
			if (is_plane && pl_q[ring_b].seen < 2'd3) begin
				for (int k = 0; k < 3; k++) begin
					pl_n[ring_b].pt[pidx + 4'(k)] = pos[k];
				end
				pl_n[ring_b].seen = pl_q[ring_b].seen + 2'd1;
			end
		end
	end

	// Job handed to the back end on the last atom of ring B
	always_comb begin
		for (int r = 0; r < 2; r++) begin
			for (int k = 0; k < 3; k++) begin
				job_sums[(r*3+k)*SW +: SW] = sum_n[r][k];
			end
			job_cnts[r*CW +: CW] = cnt_n[r];
		end
		job_plane_a = pl_n[0];
		job_plane_b = pl_n[1];
	end

	// Accumulators, cleared once a pair is handed off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 2; r++) begin
				for (int k = 0; k < 3; k++) begin
					sum_q[r][k] <= '0;
				end
				cnt_q[r] <= '0;
				pl_q[r]  <= '0;
			end
		end else if (q_push) begin
			for (int r = 0; r < 2; r++) begin
				for (int k = 0; k < 3; k++) begin
					sum_q[r][k] <= '0;
				end
				cnt_q[r]     <= '0;
				pl_q[r].seen <= '0;
			end
		end else if (acc) begin
			sum_q <= sum_n;
			cnt_q <= cnt_n;
			pl_q  <= pl_n;
		end
	end

endmodule

// File: rtl/rsp_queue.sv
module rsp_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= wdata;
		end
	end

	// Two-entry pointer queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/rsp_div.sv
module rsp_div #(
	parameter int CW = 5,
	parameter int SW = 29
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [SW-1:0] dividend,
	input  logic [CW-1:0]        divisor,
	output logic                 done,
	output logic signed [SW-1:0] quot
);

	localparam int NW = $clog2(SW + 1);

	logic [SW-1:0] quo_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] dvs_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          neg_q;
	logic          done_q;
	logic [CW:0]   r2;
	logic          fit;

	// Restoring step: one quotient bit per cycle
	assign r2   = {rem_q, quo_q[SW-1]};
	assign fit  = (r2 >= {1'b0, dvs_q});
	assign done = done_q;
	assign quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			neg_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend[SW-1] ? -dividend : dividend;
				neg_q  <= dividend[SW-1];
				rem_q  <= '0;
				dvs_q  <= divisor;
				cnt_q  <= NW'(SW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fit ? CW'(r2 - {1'b0, dvs_q}) : CW'(r2);
				quo_q <= {quo_q[SW-2:0], fit};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/rsp_sqrt.sv
module rsp_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rsp_pkg::SQRT_IN_W-1:0]     x,
	output logic                              done,
	output logic [rsp_pkg::SQRT_OUT_W-1:0]    root
);

	localparam int OW = rsp_pkg::SQRT_OUT_W;
	localparam int IW = rsp_pkg::SQRT_IN_W;
	localparam int RW = OW + 3;
	localparam int NW = $clog2(OW + 1);

	logic [IW-1:0] x_q;
	logic [RW-1:0] rem_q;
	logic [OW-1:0] root_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [RW-1:0] r4;
	logic [RW-1:0] trial;
	logic          fit;

	// Digit-by-digit square root, one result bit per cycle
	assign r4    = {rem_q[RW-3:0], x_q[IW-1:IW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fit   = (r4 >= trial);
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q    <= x;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= NW'(OW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				x_q    <= {x_q[IW-3:0], 2'b00};
				rem_q  <= fit ? r4 - trial : r4;
				root_q <= {root_q[OW-2:0], fit};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/rsp_back.sv
module rsp_back #(
	parameter int CW = 5,
	parameter int SW = 29
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic [6*SW-1:0]               job_sums,
	input  logic [2*CW-1:0]               job_cnts,
	input  rsp_pkg::plane_t               job_plane_a,
	input  rsp_pkg::plane_t               job_plane_b,
	input  logic [rsp_pkg::DL_W-1:0]      dist_limit,
	input  logic [rsp_pkg::COS_W-1:0]     cos_limit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          stacked,
	output logic                          dist_ok,
	output logic                          angle_ok,
	output logic [rsp_pkg::CD_W-1:0]      centre_dist
);

	localparam int CWD = rsp_pkg::COORD_W;
	localparam int MW  = rsp_pkg::MUL_W;
	localparam int AW  = rsp_pkg::ACC_W;
	localparam int GW  = rsp_pkg::MAG_W;
	localparam int NW  = rsp_pkg::NRM_W;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_DIV_WAIT, S_MUL, S_ACC, S_SQRT, S_SQRT_WAIT,
		S_NRM_START, S_RED, S_RHS, S_CMP, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		P_DSQ, P_DL, P_CR, P_NSQ, P_DOT, P_LL
	} phase_t;

	state_t state_q;
	phase_t ph_q;
	logic [2:0] i_q;
	logic       r_q;

	logic signed [CWD-1:0]  cen_q [6];
	logic signed [AW-1:0]   prod_q;
	logic signed [AW-1:0]   acc_q;
	logic [rsp_pkg::SQ_W-1:0]      sq_q;
	logic [rsp_pkg::SQRT_IN_W-1:0] sqx_q;
	logic [GW-1:0]          mg_q [3];
	logic                   sg_q [3];
	logic signed [NW-1:0]   n_q [2][3];
	logic                   nv_q [2];
	logic [NW-1:0]          l_q [2];
	logic signed [rsp_pkg::DOT_W-1:0] dot_q;
	logic [rsp_pkg::RHS_W-1:0] rhs_q;
	logic                   dok_q;
	logic                   aok_q;
	logic [rsp_pkg::CD_W-1:0] cdist_q;
	logic                   out_valid_q;
	logic                   stk_o_q, dok_o_q, aok_o_q;
	logic [rsp_pkg::CD_W-1:0] cd_o_q;

	// Job fields from the queue head
	logic signed [SW-1:0] sum_w [6];
	logic [CW-1:0]        cnt_w [2];
	rsp_pkg::plane_t      pl_w [2];
	logic                 both_nz;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			sum_w[i] = $signed(job_sums[i*SW +: SW]);
		end
		for (int r = 0; r < 2; r++) begin
			cnt_w[r] = job_cnts[r*CW +: CW];
		end
		pl_w[0] = job_plane_a;
		pl_w[1] = job_plane_b;
	end

	assign both_nz = (cnt_w[0] != '0) && (cnt_w[1] != '0);

	// Centre division unit
	logic                 div_done;
	logic signed [SW-1:0] div_quot;

	rsp_div #(.CW(CW), .SW(SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIV),
		.dividend (sum_w[i_q]),
		.divisor  (cnt_w[i_q >= 3'd3]),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Square root unit
	logic                            sq_done;
	logic [rsp_pkg::SQRT_OUT_W-1:0]  sq_root;

	rsp_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_SQRT),
		.x      (sqx_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Edge vectors of the current ring's plane
	logic signed [CWD:0] av [3];
	logic signed [CWD:0] bv [3];
	logic signed [CWD:0] dv;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			av[k] = $signed({pl_w[r_q].pt[3+k][CWD-1], pl_w[r_q].pt[3+k]})
				- $signed({pl_w[r_q].pt[k][CWD-1], pl_w[r_q].pt[k]});
			bv[k] = $signed({pl_w[r_q].pt[6+k][CWD-1], pl_w[r_q].pt[6+k]})
				- $signed({pl_w[r_q].pt[k][CWD-1], pl_w[r_q].pt[k]});
		end
		dv = $signed({cen_q[i_q][CWD-1], cen_q[i_q]})
			- $signed({cen_q[i_q + 3'd3][CWD-1], cen_q[i_q + 3'd3]});
	end

	// Shared multiplier operand select
	logic signed [MW-1:0] mul_a;
	logic signed [MW-1:0] mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ph_q)
			P_DSQ: begin
				mul_a = MW'(dv);
				mul_b = MW'(dv);
			end
			P_DL: begin
				mul_a = $signed(MW'(dist_limit));
				mul_b = $signed(MW'(dist_limit));
			end
			P_CR: begin
				case (i_q)
					3'd0: begin mul_a = MW'(av[1]); mul_b = MW'(bv[2]); end
					3'd1: begin mul_a = MW'(av[2]); mul_b = MW'(bv[1]); end
					3'd2: begin mul_a = MW'(av[2]); mul_b = MW'(bv[0]); end
					3'd3: begin mul_a = MW'(av[0]); mul_b = MW'(bv[2]); end
					3'd4: begin mul_a = MW'(av[0]); mul_b = MW'(bv[1]); end
					3'd5: begin mul_a = MW'(av[1]); mul_b = MW'(bv[0]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			P_NSQ: begin
				mul_a = MW'(n_q[r_q][i_q[1:0]]);
				mul_b = MW'(n_q[r_q][i_q[1:0]]);
			end
			P_DOT: begin
				mul_a = MW'(n_q[0][i_q[1:0]]);
				mul_b = MW'(n_q[1][i_q[1:0]]);
			end
			P_LL: begin
				mul_a = $signed(MW'(l_q[0]));
				mul_b = $signed(MW'(l_q[1]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Accumulate: cross products alternate load and subtract
	logic signed [AW-1:0] acc_base;
	logic signed [AW-1:0] acc_nxt;
	logic [AW-1:0]        acc_mag;
	logic                 cr_sub;

	always_comb begin
		cr_sub   = (ph_q == P_CR) && i_q[0];
		acc_base = ((i_q == 3'd0) || ((ph_q == P_CR) && !i_q[0])) ? '0 : acc_q;
		acc_nxt  = cr_sub ? acc_base - prod_q : acc_base + prod_q;
		acc_mag  = acc_nxt[AW-1] ? AW'(-acc_nxt) : AW'(acc_nxt);
	end

	// Normal reduction flags
	logic red_big;
	logic red_zero;

	always_comb begin
		red_big  = 1'b0;
		red_zero = 1'b1;
		for (int k = 0; k < 3; k++) begin
			if (mg_q[k][GW-1:rsp_pkg::RED_LIM] != '0) begin
				red_big = 1'b1;
			end
			if (mg_q[k] != '0) begin
				red_zero = 1'b0;
			end
		end
	end

	assign q_pop = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= P_DSQ;
			i_q         <= '0;
			r_q         <= 1'b0;
			prod_q      <= '0;
			acc_q       <= '0;
			sq_q        <= '0;
			sqx_q       <= '0;
			dot_q       <= '0;
			rhs_q       <= '0;
			dok_q       <= 1'b0;
			aok_q       <= 1'b0;
			cdist_q     <= '0;
			out_valid_q <= 1'b0;
			stk_o_q     <= 1'b0;
			dok_o_q     <= 1'b0;
			aok_o_q     <= 1'b0;
			cd_o_q      <= '0;
			for (int i = 0; i < 6; i++) begin
				cen_q[i] <= '0;
			end
			for (int k = 0; k < 3; k++) begin
				mg_q[k] <= '0;
				sg_q[k] <= 1'b0;
			end
			for (int r = 0; r < 2; r++) begin
				nv_q[r] <= 1'b0;
				l_q[r]  <= '0;
				for (int k = 0; k < 3; k++) begin
					n_q[r][k] <= '0;
				end
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						i_q <= '0;
						r_q <= 1'b0;
						if (both_nz) begin
							state_q <= S_DIV;
						end else begin
							dok_q   <= 1'b0;
							cdist_q <= '0;
							state_q <= S_NRM_START;
						end
					end
				end
				S_DIV: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						cen_q[i_q] <= div_quot[CWD-1:0];
						if (i_q == 3'd5) begin
							i_q     <= '0;
							ph_q    <= P_DSQ;
							state_q <= S_MUL;
						end else begin
							i_q     <= i_q + 3'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_MUL: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_nxt;
					case (ph_q)
						P_DSQ: begin
							if (i_q == 3'd2) begin
								sq_q <= acc_nxt[rsp_pkg::SQ_W-1:0];
								i_q  <= '0;
								ph_q <= P_DL;
							end else begin
								i_q <= i_q + 3'd1;
							end
							state_q <= S_MUL;
						end
						P_DL: begin
							dok_q   <= (sq_q <= rsp_pkg::SQ_W'(prod_q[2*rsp_pkg::DL_W-1:0]));
							sqx_q   <= rsp_pkg::SQRT_IN_W'(sq_q);
							state_q <= S_SQRT;
						end
						P_CR: begin
							if (i_q[0]) begin
								mg_q[i_q[2:1]] <= acc_mag[GW-1:0];
								sg_q[i_q[2:1]] <= acc_nxt[AW-1];
							end
							if (i_q == 3'd5) begin
								state_q <= S_RED;
							end else begin
								i_q     <= i_q + 3'd1;
								state_q <= S_MUL;
							end
						end
						P_NSQ: begin
							if (i_q == 3'd2) begin
								sqx_q   <= acc_nxt[rsp_pkg::SQRT_IN_W-1:0];
								state_q <= S_SQRT;
							end else begin
								i_q     <= i_q + 3'd1;
								state_q <= S_MUL;
							end
						end
						P_DOT: begin
							if (i_q == 3'd2) begin
								dot_q <= acc_nxt[rsp_pkg::DOT_W-1:0];
								i_q   <= '0;
								ph_q  <= P_LL;
							end else begin
								i_q <= i_q + 3'd1;
							end
							state_q <= S_MUL;
						end
						P_LL: begin
							state_q <= S_RHS;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SQRT: begin
					state_q <= S_SQRT_WAIT;
				end
				S_SQRT_WAIT: begin
					if (sq_done) begin
						if (ph_q == P_DL) begin
							cdist_q <= (sq_root[rsp_pkg::SQRT_OUT_W-1:rsp_pkg::CD_W] != '0)
								? '1 : sq_root[rsp_pkg::CD_W-1:0];
							r_q     <= 1'b0;
							state_q <= S_NRM_START;
						end else begin
							l_q[r_q] <= sq_root[NW-1:0];
							i_q      <= '0;
							if (r_q == 1'b0) begin
								r_q     <= 1'b1;
							end else begin
								ph_q    <= P_DOT;
							end
							state_q <= S_MUL;
						end
					end
				end
				S_NRM_START: begin
					i_q <= '0;
					if (pl_w[r_q].seen < 2'd3) begin
						nv_q[r_q] <= 1'b0;
						if (r_q == 1'b0) begin
							r_q <= 1'b1;
						end else begin
							aok_q   <= 1'b0;
							state_q <= S_OUT;
						end
					end else begin
						ph_q    <= P_CR;
						state_q <= S_MUL;
					end
				end
				S_RED: begin
					if (red_zero || !red_big) begin
						nv_q[r_q] <= !red_zero;
						for (int k = 0; k < 3; k++) begin
							n_q[r_q][k] <= sg_q[k] ? -$signed({1'b0, mg_q[k][NW-2:0]})
								: $signed({1'b0, mg_q[k][NW-2:0]});
						end
						i_q <= '0;
						if (r_q == 1'b0) begin
							r_q     <= 1'b1;
							state_q <= S_NRM_START;
						end else if (nv_q[0] && !red_zero) begin
							r_q     <= 1'b0;
							ph_q    <= P_NSQ;
							state_q <= S_MUL;
						end else begin
							aok_q   <= 1'b0;
							state_q <= S_OUT;
						end
					end else begin
						// shift all components until the largest drops below 2^20
						for (int k = 0; k < 3; k++) begin
							mg_q[k] <= mg_q[k] >> 1;
						end
					end
				end
				S_RHS: begin
					rhs_q   <= cos_limit * prod_q[rsp_pkg::LL_W-1:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					aok_q   <= $signed({dot_q, 16'h0000})
						>= $signed({1'b0, rhs_q});
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						stk_o_q     <= dok_q && aok_q;
						dok_o_q     <= dok_q;
						aok_o_q     <= aok_q;
						cd_o_q      <= cdist_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign stacked     = stk_o_q;
	assign dist_ok     = dok_o_q;
	assign angle_ok    = aok_o_q;
	assign centre_dist = cd_o_q;

endmodule

// File: rtl/ring_stacking_pair_test.sv
// Ring pair stacking test: atoms of ring A then ring B, one result per pair.
// Throughput: one atom per cycle while the two-entry pair queue has room.
// The delay from the last atom of ring B to the result is set by the serial
// centre divider, the bit-serial square root and the normal reduction shifter.
// Reset (arst_n low) clears all accumulators, the queue and the result, and
// loads dist_limit = 0.5 nm and cos_limit = cos 30 degrees.
module ring_stacking_pair_test #(
	parameter int MAX_RING_ATOMS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                ring_b,
	input  logic                                is_plane,
	input  logic signed [rsp_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [rsp_pkg::COORD_W-1:0]  pos_y,
	input  logic signed [rsp_pkg::COORD_W-1:0]  pos_z,
	input  logic                                last_atom,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                stacked,
	output logic                                dist_ok,
	output logic                                angle_ok,
	output logic [rsp_pkg::CD_W-1:0]            centre_dist,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rsp_pkg::ADDR_W-1:0]          paddr,
	input  logic [rsp_pkg::DATA_W-1:0]          pwdata,
	output logic [rsp_pkg::DATA_W-1:0]          prdata,
	output logic                                pready
);

	localparam int CW = $clog2(MAX_RING_ATOMS + 1);
	localparam int SW = rsp_pkg::COORD_W + CW;
	localparam int PW = $bits(rsp_pkg::plane_t);
	localparam int QW = 6 * SW + 2 * CW + 2 * PW;

	// Configuration registers
	logic [rsp_pkg::DL_W-1:0]  dist_limit_q;
	logic [rsp_pkg::COS_W-1:0] cos_limit_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_limit_q <= rsp_pkg::DL_RESET;
			cos_limit_q  <= rsp_pkg::COS_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				rsp_pkg::REG_DIST_LIMIT: dist_limit_q <= pwdata[rsp_pkg::DL_W-1:0];
				rsp_pkg::REG_COS_LIMIT:  cos_limit_q  <= pwdata[rsp_pkg::COS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rsp_pkg::REG_DIST_LIMIT: prdata = rsp_pkg::DATA_W'(dist_limit_q);
			rsp_pkg::REG_COS_LIMIT:  prdata = rsp_pkg::DATA_W'(cos_limit_q);
			default:                 prdata = '0;
		endcase
	end

	// Front end: accumulate atoms per ring
	logic            q_full;
	logic            q_push;
	logic [6*SW-1:0] f_sums;
	logic [2*CW-1:0] f_cnts;
	rsp_pkg::plane_t f_pa;
	rsp_pkg::plane_t f_pb;

	rsp_front #(.MAX_RING_ATOMS(MAX_RING_ATOMS), .CW(CW), .SW(SW)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ring_b      (ring_b),
		.is_plane    (is_plane),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.last_atom   (last_atom),
		.q_full      (q_full),
		.q_push      (q_push),
		.job_sums    (f_sums),
		.job_cnts    (f_cnts),
		.job_plane_a (f_pa),
		.job_plane_b (f_pb)
	);

	// Pair queue between front and back
	logic          q_valid;
	logic          q_pop;
	logic [QW-1:0] q_rdata;

	rsp_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_sums, f_cnts, f_pa, f_pb}),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	// Back end: centre distance and normal angle test
	rsp_back #(.CW(CW), .SW(SW)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.job_sums    (q_rdata[QW-1 -: 6*SW]),
		.job_cnts    (q_rdata[2*PW +: 2*CW]),
		.job_plane_a (q_rdata[PW +: PW]),
		.job_plane_b (q_rdata[0 +: PW]),
		.dist_limit  (dist_limit_q),
		.cos_limit   (cos_limit_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.stacked     (stacked),
		.dist_ok     (dist_ok),
		.angle_ok    (angle_ok),
		.centre_dist (centre_dist)
	);

endmodule
